/* src/tlvsfp_pkg.sv */
// Shared types and constants for the TLV segment frame parser.
package tlvsfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic [7:0] RST_PROPERTY_CMD = 8'h35;
  localparam logic [7:0] RST_FACTORY_CMD  = 8'h36;
  localparam logic [7:0] RST_SNAPSHOT_CMD = 8'h37;
  localparam logic [7:0] RST_FACTORY_TYPE = 8'h6A;

  // Smallest payload that can hold a segment header
  localparam logic [15:0] SEG_HDR_BYTES = 16'd3;

  localparam int TDATA_W = 56;
  localparam int TUSER_W = 3;
  localparam int PADDR_W = 4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC,
    PH_LENH,
    PH_LENL,
    PH_CMD,
    PH_TYPE,
    PH_SLH,
    PH_SLL,
    PH_DATA,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    CK_PROPERTY,
    CK_SNAPSHOT,
    CK_FACTORY,
    CK_UNKNOWN
  } cmd_kind_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_START,
    KIND_DATA
  } kind_e;

  typedef enum logic [3:0] {
    ST_PROPERTY_READY,
    ST_SNAPSHOT_READY,
    ST_FACTORY_OK,
    ST_NO_SEGMENT,
    ST_UNKNOWN_CMD,
    ST_BAD_HEADER,
    ST_PAYLOAD_SHORT,
    ST_WRONG_TYPE,
    ST_FACTORY_LONG
  } status_e;

  // Held error code; zero means no error
  localparam logic [3:0] ERR_NONE = 4'd0;

  typedef enum logic [1:0] {
    REG_PROPERTY_CMD,
    REG_FACTORY_CMD,
    REG_SNAPSHOT_CMD,
    REG_FACTORY_TYPE
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] property_cmd;
    logic [7:0] factory_cmd;
    logic [7:0] snapshot_cmd;
    logic [7:0] factory_type;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  segment_type;
    logic [15:0] segment_length;
    logic        segment_last;
    logic [14:0] segment_number;
    logic        message_done;
    status_e     status;
  } res_t;

endpackage

/* src/tlvsfp_cfg_regs.sv */
// APB register file holding the command bytes and the factory segment type.
module tlvsfp_cfg_regs
  import tlvsfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.property_cmd <= RST_PROPERTY_CMD;
      cfg_q.factory_cmd  <= RST_FACTORY_CMD;
      cfg_q.snapshot_cmd <= RST_SNAPSHOT_CMD;
      cfg_q.factory_type <= RST_FACTORY_TYPE;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROPERTY_CMD: cfg_q.property_cmd <= pwdata[7:0];
        REG_FACTORY_CMD:  cfg_q.factory_cmd  <= pwdata[7:0];
        REG_SNAPSHOT_CMD: cfg_q.snapshot_cmd <= pwdata[7:0];
        REG_FACTORY_TYPE: cfg_q.factory_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PROPERTY_CMD: prdata[7:0] = cfg_q.property_cmd;
      REG_FACTORY_CMD:  prdata[7:0] = cfg_q.factory_cmd;
      REG_SNAPSHOT_CMD: prdata[7:0] = cfg_q.snapshot_cmd;
      REG_FACTORY_TYPE: prdata[7:0] = cfg_q.factory_type;
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/tlvsfp_parser.sv */
// Message state and the per-byte update that yields one result word per byte.
module tlvsfp_parser
  import tlvsfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] size_q, size_d;
  logic [15:0] off_q, off_d;
  cmd_kind_e   cmd_q, cmd_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [14:0] seen_q, seen_d;
  logic [3:0]  err_q, err_d;

  logic [15:0] off_inc;
  logic [15:0] len_new;
  logic [16:0] end_sum;
  logic [16:0] room;
  logic        seg_end;
  res_t        res;

  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    off_d   = off_q;
    cmd_d   = cmd_q;
    type_d  = type_q;
    len_d   = len_q;
    left_d  = left_q;
    seen_d  = seen_q;
    err_d   = err_q;
    res     = '0;
    seg_end = 1'b0;
    off_inc = off_q + 16'd1;
    len_new = {len_q[15:8], byte_i};
    end_sum = {1'b0, off_inc} + {1'b0, len_new};
    room    = {1'b0, size_q} - {1'b0, off_inc};

    if (start_i) begin
      size_d = '0;
      off_d  = '0;
      cmd_d  = CK_PROPERTY;
      type_d = '0;
      len_d  = '0;
      left_d = '0;
      seen_d = '0;
      err_d  = ERR_NONE;
      if (byte_i == SYNC_FIRST) begin
        phase_d = PH_SYNC;
      end else begin
        res.message_done = 1'b1;
        res.status       = ST_BAD_HEADER;
        phase_d          = PH_IDLE;
      end
    end else begin
      case (phase_q)
        PH_SYNC: begin
          if (byte_i == SYNC_SECOND) begin
            phase_d = PH_LENH;
          end else begin
            res.message_done = 1'b1;
            res.status       = ST_BAD_HEADER;
            phase_d          = PH_IDLE;
          end
        end
        PH_LENH: begin
          size_d  = {byte_i, 8'h00};
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          size_d  = {size_q[15:8], byte_i};
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          priority if (byte_i == cfg_i.property_cmd) cmd_d = CK_PROPERTY;
          else if (byte_i == cfg_i.factory_cmd)      cmd_d = CK_FACTORY;
          else if (byte_i == cfg_i.snapshot_cmd)     cmd_d = CK_SNAPSHOT;
          else                                       cmd_d = CK_UNKNOWN;
          if (cmd_d == CK_UNKNOWN) begin
            err_d = 4'(ST_UNKNOWN_CMD);
            if (size_q == '0) begin
              res.message_done = 1'b1;
              res.status       = ST_UNKNOWN_CMD;
              phase_d          = PH_IDLE;
            end else begin
              phase_d = PH_SKIP;
            end
          end else if (size_q < SEG_HDR_BYTES) begin
            res.message_done = 1'b1;
            res.status       = ST_PAYLOAD_SHORT;
            phase_d          = PH_IDLE;
          end else begin
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE, PH_SLH, PH_SLL, PH_DATA, PH_SKIP: begin
          off_d = off_inc;
          case (phase_q)
            PH_TYPE: begin
              type_d = byte_i;
              if (cmd_q == CK_FACTORY && byte_i != cfg_i.factory_type) begin
                err_d   = 4'(ST_WRONG_TYPE);
                phase_d = PH_SKIP;
              end else begin
                phase_d = PH_SLH;
              end
            end
            PH_SLH: begin
              len_d   = {byte_i, 8'h00};
              phase_d = PH_SLL;
            end
            PH_SLL: begin
              len_d = len_new;
              if (end_sum > {1'b0, size_q}) begin
                if (cmd_q == CK_FACTORY) err_d = 4'(ST_FACTORY_LONG);
                phase_d = PH_SKIP;
              end else begin
                res.kind           = KIND_START;
                res.segment_type   = type_q;
                res.segment_length = len_new;
                res.segment_number = seen_q;
                left_d             = len_new;
                if (len_new == '0) seg_end = 1'b1;
                else               phase_d = PH_DATA;
              end
            end
            PH_DATA: begin
              res.kind           = KIND_DATA;
              res.data_byte      = byte_i;
              res.segment_type   = type_q;
              res.segment_length = len_q;
              res.segment_number = seen_q;
              left_d             = left_q - 16'd1;
              if (left_d == '0) begin
                res.segment_last = 1'b1;
                seg_end          = 1'b1;
              end
            end
            default: ;
          endcase
          if (seg_end) begin
            seen_d = seen_q + 15'd1;
            // room is negative only when the offset has passed the payload size
            if (cmd_q == CK_FACTORY || (!room[16] && room[15:0] < SEG_HDR_BYTES))
              phase_d = PH_SKIP;
            else
              phase_d = PH_TYPE;
          end
          if (off_inc >= size_q) begin
            res.message_done = 1'b1;
            phase_d          = PH_IDLE;
            priority if (err_d != ERR_NONE) res.status = status_e'(err_d);
            else if (cmd_q == CK_FACTORY)   res.status = ST_FACTORY_OK;
            else if (seen_d == '0)          res.status = ST_NO_SEGMENT;
            else if (cmd_q == CK_SNAPSHOT)  res.status = ST_SNAPSHOT_READY;
            else                            res.status = ST_PROPERTY_READY;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      size_q  <= '0;
      off_q   <= '0;
      cmd_q   <= CK_PROPERTY;
      type_q  <= '0;
      len_q   <= '0;
      left_q  <= '0;
      seen_q  <= '0;
      err_q   <= ERR_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      off_q   <= off_d;
      cmd_q   <= cmd_d;
      type_q  <= type_d;
      len_q   <= len_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
      err_q   <= err_d;
    end
  end

  assign res_o = res;

endmodule

/* src/tlvsfp_out_buf.sv */
// Result register with a skid stage so the parser can finish the word in hand under a stall.
module tlvsfp_out_buf
  import tlvsfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic ready_o,
  output logic valid_o,
  output res_t data_o,
  input  logic pop_ready_i
);

  logic main_v_q;
  logic skid_v_q;
  res_t main_q;
  res_t skid_q;
  logic pop;
  logic load_main;

  assign pop       = main_v_q & pop_ready_i;
  assign load_main = pop | ~main_v_q;
  assign ready_o   = ~skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_main) begin
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main) begin
      main_q <= skid_v_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign valid_o = main_v_q;
  assign data_o  = main_q;

endmodule

/* src/tlv_segment_frame_parser_unit.sv */
// Top level of the TLV segment frame parser: input register, parser, result buffer, APB.
//
// Takes one message byte per cycle on the slave stream while the master stream
// is not stalled, and returns exactly one result word for every byte, in order,
// at a sustained rate of one word per cycle. Each byte passes the input register
// and then the result register. The per-byte state update is a single short
// step from the input register into the result register, and a skid stage
// beside the result register lets the parser finish the word in hand while the
// output is stalled. Command bytes and the factory segment type are written
// over APB at byte addresses 0, 4, 8 and 12 by the user only while the stream is
// idle; the block does not enforce this. pready is tied high.
module tlv_segment_frame_parser_unit
  import tlvsfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] byte_in
  input  logic [0:0]         s_axis_tuser,   // [0] msg_start
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [7:0] data_byte, [15:8] segment_type, [31:16] segment_length,
  // [46:32] segment_number, [50:47] status, [55:51] zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser,   // [1:0] kind, [2] segment_last
  output logic               m_axis_tlast,   // message_done
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       buf_ready;
  logic       advance;
  cfg_t       cfg;
  res_t       res;
  res_t       out_res;

  assign pready = 1'b1;

  tlvsfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign advance       = in_v_q & buf_ready;
  assign s_axis_tready = ~in_v_q | buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
  end

  tlvsfp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  tlvsfp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'b0, out_res.status, out_res.segment_number,
                         out_res.segment_length, out_res.segment_type,
                         out_res.data_byte};
  assign m_axis_tuser = {out_res.segment_last, out_res.kind};
  assign m_axis_tlast = out_res.message_done;

  // A stalled input side always has a word parked in the input register
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_v_q)
    else $error("input side stalled with empty input register");

  // Status only carries meaning on the word that ends a message
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (out_res.status == ST_PROPERTY_READY))
    else $error("status set on a word that does not end a message");

  // Data byte and last flag appear only on data words
  a_data_only_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.kind != KIND_DATA) |->
      (out_res.data_byte == 8'd0 && !out_res.segment_last))
    else $error("data fields set on a non-data word");

  // A word accepted into the parser lands in the buffer on the next edge
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("parsed word did not reach the output");

endmodule
